FILE: hdl/rmq_pkg.sv
// Shared constants and codes for the rotation matrix to quaternion core.
package rmq_pkg;

    localparam int IN_W  = 32;
    localparam int OUT_W = 32;
    localparam int LANES = 3;
    localparam int MAG_W = 33;
    localparam int QN    = 33;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2,
        AX_W = 2'd3
    } t_axis;

endpackage

FILE: hdl/rmq_if.sv
// Valid/ready channel interfaces for matrix input beats and quaternion output beats.
interface rmq_in_if;
    logic valid;
    logic ready;
    logic signed [rmq_pkg::IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
    modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_out_if;
    logic valid;
    logic ready;
    logic signed [rmq_pkg::OUT_W-1:0] quat_x, quat_y, quat_z, quat_w;
    logic degenerate;

    modport source(output valid, quat_x, quat_y, quat_z, quat_w, degenerate, input ready);
    modport sink(input valid, quat_x, quat_y, quat_z, quat_w, degenerate, output ready);
endinterface

FILE: hdl/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to unit quaternion core, a fully pipelined Shepperd converter.
// One beat is accepted per cycle while the output is not stalled; the square root
// takes one stage per result bit and the three dividers one stage per quotient bit,
// so the stage count sets the latency.
// A stall at the output freezes every stage together; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = 30
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_in_if.sink     i_in,
    rmq_out_if.source  o_out
);

    localparam int F     = FRAC_BITS;
    localparam int RS_W  = ((F > 33) ? F : 33) + 3;
    localparam int RAD_W = RS_W - 1;
    localparam int XW    = RAD_W + F - 2;
    localparam int SQ_N  = (XW + 1) / 2;
    localparam int SX    = 2 * SQ_N;
    localparam int BW    = SQ_N;
    localparam int RW    = BW + 3;
    localparam int DW    = BW + 2;
    localparam int MW    = rmq_pkg::MAG_W;
    localparam int QN    = rmq_pkg::QN;
    localparam int NW    = MW + F;
    localparam int CW    = NW + DW;
    localparam int LN    = rmq_pkg::LANES;
    localparam int OW    = rmq_pkg::OUT_W;
    localparam logic [RS_W-1:0] ONE_V = {{(RS_W-1){1'b0}}, 1'b1} << F;

    typedef struct packed {
        rmq_pkg::t_axis      big;
        logic                degen;
        logic [LN-1:0][MW-1:0] mag;
        logic [LN-1:0]       neg;
    } t_meta;

    logic w_en;
    logic r_o_v;

    assign w_en       = !r_o_v || o_out.ready;
    assign i_in.ready = w_en;

    // Stage A: trace, comparisons, off-diagonal sums and differences.
    logic                  r_a_v;
    logic signed [33:0]    r_a_trace;
    logic signed [31:0]    r_a_d00, r_a_d11, r_a_d22;
    logic signed [32:0]    r_a_dx, r_a_dy, r_a_dz, r_a_sa, r_a_sb, r_a_sc;
    logic                  r_a_c01, r_a_c12, r_a_c02;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_trace <= 34'(i_in.m00) + 34'(i_in.m11) + 34'(i_in.m22);
            r_a_d00   <= i_in.m00;
            r_a_d11   <= i_in.m11;
            r_a_d22   <= i_in.m22;
            r_a_dx    <= 33'(i_in.m21) - 33'(i_in.m12);
            r_a_dy    <= 33'(i_in.m02) - 33'(i_in.m20);
            r_a_dz    <= 33'(i_in.m10) - 33'(i_in.m01);
            r_a_sa    <= 33'(i_in.m10) + 33'(i_in.m01);
            r_a_sb    <= 33'(i_in.m20) + 33'(i_in.m02);
            r_a_sc    <= 33'(i_in.m21) + 33'(i_in.m12);
            r_a_c01   <= i_in.m00 < i_in.m11;
            r_a_c12   <= i_in.m11 < i_in.m22;
            r_a_c02   <= i_in.m00 < i_in.m22;
        end
    end

    // Stage B: branch choice, radicand and lane magnitudes.
    logic                r_b_v;
    logic [RAD_W-1:0]    r_b_rad;
    t_meta               r_b_meta;
    t_meta               n_b_meta;
    logic [RAD_W-1:0]    n_b_rad;

    always_comb begin
        logic signed [RS_W-1:0] tr, e0, e1, e2, rs;
        logic signed [32:0]     lv [LN];
        tr = RS_W'(r_a_trace);
        e0 = RS_W'(r_a_d00);
        e1 = RS_W'(r_a_d11);
        e2 = RS_W'(r_a_d22);
        lv[0] = r_a_dx;
        lv[1] = r_a_dy;
        lv[2] = r_a_dz;
        if (r_a_trace > 34'sd0) begin
            n_b_meta.big = rmq_pkg::AX_W;
            rs = tr + $signed(ONE_V);
        end else if (r_a_c01 ? r_a_c12 : r_a_c02) begin
            n_b_meta.big = rmq_pkg::AX_Z;
            rs = e2 - e0 - e1 + $signed(ONE_V);
            lv[0] = r_a_dz;
            lv[1] = r_a_sb;
            lv[2] = r_a_sc;
        end else if (r_a_c01) begin
            n_b_meta.big = rmq_pkg::AX_Y;
            rs = e1 - e2 - e0 + $signed(ONE_V);
            lv[0] = r_a_dy;
            lv[1] = r_a_sc;
            lv[2] = r_a_sa;
        end else begin
            n_b_meta.big = rmq_pkg::AX_X;
            rs = e0 - e1 - e2 + $signed(ONE_V);
            lv[0] = r_a_dx;
            lv[1] = r_a_sa;
            lv[2] = r_a_sb;
        end
        n_b_meta.degen = (rs <= $signed({RS_W{1'b0}}));
        n_b_rad = n_b_meta.degen ? '0 : rs[RAD_W-1:0];
        for (int l = 0; l < LN; l++) begin
            n_b_meta.neg[l] = lv[l][32];
            n_b_meta.mag[l] = lv[l][32] ? MW'(-lv[l]) : MW'(lv[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_rad  <= n_b_rad;
            r_b_meta <= n_b_meta;
        end
    end

    // Square root, one result bit per stage.
    logic             r_sq_v    [SQ_N];
    logic [RW-1:0]    r_sq_rem  [SQ_N];
    logic [BW-1:0]    r_sq_root [SQ_N];
    logic [RAD_W-1:0] r_sq_rad  [SQ_N];
    t_meta            r_sq_meta [SQ_N];

    for (genvar s = 0; s < SQ_N; s++) begin : g_sq
        logic             v_in;
        logic [RW-1:0]    rem_in;
        logic [BW-1:0]    root_in;
        logic [RAD_W-1:0] rad_in;
        t_meta            meta_in;
        logic [SX-1:0]    xv;
        logic [RW-1:0]    rem_sh, trial;
        logic             ge;

        if (s == 0) begin : g_first
            assign v_in    = r_b_v;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = r_b_rad;
            assign meta_in = r_b_meta;
        end else begin : g_next
            assign v_in    = r_sq_v[s-1];
            assign rem_in  = r_sq_rem[s-1];
            assign root_in = r_sq_root[s-1];
            assign rad_in  = r_sq_rad[s-1];
            assign meta_in = r_sq_meta[s-1];
        end

        assign xv     = SX'(rad_in) << (F - 2);
        assign rem_sh = {rem_in[RW-3:0], xv[SX-1-2*s -: 2]};
        assign trial  = RW'({root_in, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[s] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[s]  <= ge ? rem_sh - trial : rem_sh;
                r_sq_root[s] <= {root_in[BW-2:0], ge};
                r_sq_rad[s]  <= rad_in;
                r_sq_meta[s] <= meta_in;
            end
        end
    end

    // Divider setup: overflow test and partial remainder start.
    logic                 r_p_v;
    logic [BW-1:0]        r_p_b;
    t_meta                r_p_meta;
    logic [LN-1:0]        r_p_ovf;
    logic [DW-1:0]        r_p_r [LN];
    logic [QN-1:0]        r_p_n [LN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_en) begin
            r_p_v <= r_sq_v[SQ_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] nv;
        logic [CW-1:0] hi, dd;
        if (w_en) begin
            r_p_b    <= r_sq_root[SQ_N-1];
            r_p_meta <= r_sq_meta[SQ_N-1];
            for (int l = 0; l < LN; l++) begin
                nv = {r_sq_meta[SQ_N-1].mag[l], {F{1'b0}}};
                hi = CW'(nv >> QN);
                dd = CW'({r_sq_root[SQ_N-1], 2'b00});
                r_p_ovf[l] <= hi >= dd;
                r_p_r[l]   <= hi[DW-1:0];
                r_p_n[l]   <= nv[QN-1:0];
            end
        end
    end

    // Restoring division, one quotient bit per stage, three lanes side by side.
    logic          r_dv_v    [QN];
    logic [BW-1:0] r_dv_b    [QN];
    t_meta         r_dv_meta [QN];
    logic [LN-1:0] r_dv_ovf  [QN];
    logic [DW-1:0] r_dv_r    [QN][LN];
    logic [QN-1:0] r_dv_n    [QN][LN];
    logic [QN-1:0] r_dv_q    [QN][LN];

    for (genvar t = 0; t < QN; t++) begin : g_dv
        logic          v_in;
        logic [BW-1:0] b_in;
        t_meta         meta_in;
        logic [LN-1:0] ovf_in;
        logic [DW-1:0] r_in [LN];
        logic [QN-1:0] n_in [LN];
        logic [QN-1:0] q_in [LN];

        if (t == 0) begin : g_first
            assign v_in    = r_p_v;
            assign b_in    = r_p_b;
            assign meta_in = r_p_meta;
            assign ovf_in  = r_p_ovf;
            for (genvar l = 0; l < LN; l++) begin : g_l
                assign r_in[l] = r_p_r[l];
                assign n_in[l] = r_p_n[l];
                assign q_in[l] = '0;
            end
        end else begin : g_next
            assign v_in    = r_dv_v[t-1];
            assign b_in    = r_dv_b[t-1];
            assign meta_in = r_dv_meta[t-1];
            assign ovf_in  = r_dv_ovf[t-1];
            for (genvar l = 0; l < LN; l++) begin : g_l
                assign r_in[l] = r_dv_r[t-1][l];
                assign n_in[l] = r_dv_n[t-1][l];
                assign q_in[l] = r_dv_q[t-1][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[t] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[t] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            logic [DW:0] r2, dd;
            logic        ge;
            if (w_en) begin
                r_dv_b[t]    <= b_in;
                r_dv_meta[t] <= meta_in;
                r_dv_ovf[t]  <= ovf_in;
                dd = {1'b0, b_in, 2'b00};
                for (int l = 0; l < LN; l++) begin
                    r2 = {r_in[l], n_in[l][QN-1]};
                    ge = r2 >= dd;
                    r_dv_r[t][l] <= ge ? DW'(r2 - dd) : DW'(r2);
                    r_dv_n[t][l] <= {n_in[l][QN-2:0], 1'b0};
                    r_dv_q[t][l] <= {q_in[l][QN-2:0], ge};
                end
            end
        end
    end

    // Output stage: rounding, saturation, sign and placement of components.
    logic signed [OW-1:0] r_o_x, r_o_y, r_o_z, r_o_w;
    logic                 r_o_degen;
    logic signed [OW-1:0] n_o_x, n_o_y, n_o_z, n_o_w;

    always_comb begin
        logic [DW:0]          rr, dd;
        logic [QN:0]          q1, lim, mg;
        logic signed [OW-1:0] lv [LN];
        logic [BW+OW-1:0]     bx;
        logic signed [OW-1:0] bs;
        t_meta                mt;
        mt = r_dv_meta[QN-1];
        dd = {1'b0, r_dv_b[QN-1], 2'b00};
        for (int l = 0; l < LN; l++) begin
            rr  = {r_dv_r[QN-1][l], 1'b0};
            q1  = {1'b0, r_dv_q[QN-1][l]} + (QN+1)'(rr >= dd);
            lim = mt.neg[l] ? (QN+1)'(34'h080000000) : (QN+1)'(34'h07FFFFFFF);
            mg  = (r_dv_ovf[QN-1][l] || q1 > lim) ? lim : q1;
            lv[l] = mt.neg[l] ? -OW'(mg) : OW'(mg);
        end
        bx = (BW+OW)'(r_dv_b[QN-1]);
        bs = (bx > (BW+OW)'(32'h7FFFFFFF)) ? OW'(32'h7FFFFFFF) : OW'(bx);
        n_o_x = '0;
        n_o_y = '0;
        n_o_z = '0;
        n_o_w = '0;
        if (!mt.degen) begin
            case (mt.big)
                rmq_pkg::AX_W: begin
                    n_o_w = bs;
                    n_o_x = lv[0];
                    n_o_y = lv[1];
                    n_o_z = lv[2];
                end
                rmq_pkg::AX_X: begin
                    n_o_x = bs;
                    n_o_w = lv[0];
                    n_o_y = lv[1];
                    n_o_z = lv[2];
                end
                rmq_pkg::AX_Y: begin
                    n_o_y = bs;
                    n_o_w = lv[0];
                    n_o_z = lv[1];
                    n_o_x = lv[2];
                end
                rmq_pkg::AX_Z: begin
                    n_o_z = bs;
                    n_o_w = lv[0];
                    n_o_x = lv[1];
                    n_o_y = lv[2];
                end
                default: begin
                    n_o_w = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= r_dv_v[QN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_x     <= n_o_x;
            r_o_y     <= n_o_y;
            r_o_z     <= n_o_z;
            r_o_w     <= n_o_w;
            r_o_degen <= r_dv_meta[QN-1].degen;
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.quat_x     = r_o_x;
    assign o_out.quat_y     = r_o_y;
    assign o_out.quat_z     = r_o_z;
    assign o_out.quat_w     = r_o_w;
    assign o_out.degenerate = r_o_degen;

endmodule

FILE: verif/rmq_checker.sv
// Checker that watches both channels, predicts each quaternion and compares it.
module rmq_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmq_in_if         i_in,
    rmq_out_if        i_out,
    output int        o_errors,
    output int        o_pending,
    output int        o_results,
    output int        o_degenerate_seen
);

    localparam int FB = 30;
    localparam int OW = rmq_pkg::OUT_W;

    typedef struct packed {
        logic signed [OW-1:0] qx;
        logic signed [OW-1:0] qy;
        logic signed [OW-1:0] qz;
        logic signed [OW-1:0] qw;
        logic                 degen;
    } t_quat;

    t_quat expected_quats[$];

    function automatic logic [63:0] isqrt(logic [127:0] x);
        logic [63:0]  res;
        logic [63:0]  c;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            c = res | (64'd1 << b);
            if (128'(c) * 128'(c) <= x) begin
                res = c;
            end
        end
        return res;
    endfunction

    function automatic logic signed [OW-1:0] scaled_ratio(longint diff, logic [63:0] big);
        logic          neg;
        logic [127:0]  num;
        logic [127:0]  den;
        logic [127:0]  quo;
        logic [127:0]  rem;
        logic [127:0]  lim;
        neg = diff < 0;
        num = 128'(neg ? -diff : diff) << FB;
        den = 128'(big) << 2;
        quo = num / den;
        rem = num % den;
        if (rem >= den - rem) begin
            quo = quo + 1;
        end
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim) begin
            quo = lim;
        end
        return neg ? OW'(-quo[31:0]) : OW'(quo[31:0]);
    endfunction

    function automatic t_quat matrix_to_quat(longint m[3][3]);
        t_quat       q;
        longint      tr;
        longint      rad;
        logic [63:0] big;
        logic signed [OW-1:0] c[4];
        int          ax;
        int          j;
        int          k;
        tr = m[0][0] + m[1][1] + m[2][2];
        j = 0;
        k = 0;
        if (tr > 0) begin
            rad = tr + (64'sd1 <<< FB);
            ax = rmq_pkg::AX_W;
        end else begin
            if (m[0][0] < m[1][1]) begin
                ax = (m[1][1] < m[2][2]) ? rmq_pkg::AX_Z : rmq_pkg::AX_Y;
            end else begin
                ax = (m[0][0] < m[2][2]) ? rmq_pkg::AX_Z : rmq_pkg::AX_X;
            end
            j = (ax + 1) % 3;
            k = (ax + 2) % 3;
            rad = m[ax][ax] - m[j][j] - m[k][k] + (64'sd1 <<< FB);
        end
        foreach (c[n]) c[n] = '0;
        q.degen = rad <= 0;
        if (!q.degen) begin
            big = isqrt(128'(rad) << (FB - 2));
            c[ax] = (big > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : OW'(big);
            if (ax == rmq_pkg::AX_W) begin
                c[rmq_pkg::AX_X] = scaled_ratio(m[2][1] - m[1][2], big);
                c[rmq_pkg::AX_Y] = scaled_ratio(m[0][2] - m[2][0], big);
                c[rmq_pkg::AX_Z] = scaled_ratio(m[1][0] - m[0][1], big);
            end else begin
                c[rmq_pkg::AX_W] = scaled_ratio(m[k][j] - m[j][k], big);
                c[j] = scaled_ratio(m[j][ax] + m[ax][j], big);
                c[k] = scaled_ratio(m[k][ax] + m[ax][k], big);
            end
        end
        q.qx = c[rmq_pkg::AX_X];
        q.qy = c[rmq_pkg::AX_Y];
        q.qz = c[rmq_pkg::AX_Z];
        q.qw = c[rmq_pkg::AX_W];
        return q;
    endfunction

    assign o_pending = expected_quats.size();

    always @(posedge i_clk) begin
        longint m[3][3];
        t_quat  want;
        t_quat  got;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_results <= 0;
            o_degenerate_seen <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                m[0][0] = i_in.m00; m[0][1] = i_in.m01; m[0][2] = i_in.m02;
                m[1][0] = i_in.m10; m[1][1] = i_in.m11; m[1][2] = i_in.m12;
                m[2][0] = i_in.m20; m[2][1] = i_in.m21; m[2][2] = i_in.m22;
                expected_quats.insert(expected_quats.size(), matrix_to_quat(m));
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.quat_x, i_out.quat_y, i_out.quat_z, i_out.quat_w,
                        i_out.degenerate};
                o_results <= o_results + 1;
                if (got.degen) o_degenerate_seen <= o_degenerate_seen + 1;
                if (expected_quats.size() == 0) begin
                    $display("%0t: unexpected beat, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_quats.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d d=%0b",
                                 $time, want.qx, want.qy, want.qz, want.qw, want.degen);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d d=%0b",
                                 $time, got.qx, got.qy, got.qz, got.qw, got.degen);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/tb.sv
// Top of the quaternion converter testbench: clock, reset, stimulus and verdict.
module tb;

    localparam int ONE = 1 << 30;
    localparam int N_RANDOM = 800;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   results;
    int   degen_count;
    int   sent;

    rmq_in_if  in_ch();
    rmq_out_if out_ch();

    rotation_matrix_to_quaternion_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    rmq_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (in_ch),
        .i_out            (out_ch),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_results        (results),
        .o_degenerate_seen(degen_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // The receiver stalls in runs whose style changes over the run.
    initial begin
        int mode;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (($urandom % 200) == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom % 4) != 0;
                2: out_ch.ready <= ($urandom % 4) == 0;
                default: out_ch.ready <= ($urandom % 2) == 0;
            endcase
        end
    end

    function automatic int pick_entry();
        case ($urandom % 8)
            0: return ONE;
            1: return -ONE;
            2: return 0;
            3: return int'($urandom);
            4: return $urandom_range(0, 2) - 1;
            default: return int'($urandom_range(0, 2 * ONE)) - ONE;
        endcase
    endfunction

    // Builds a true rotation from a random unit quaternion, with small noise.
    task automatic make_rotation(output int m[9]);
        real a;
        real b;
        real c;
        real d;
        real n;
        real r[9];
        a = $urandom_range(0, 2000) - 1000.0;
        b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0;
        d = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1e-9;
        a /= n; b /= n; c /= n; d /= n;
        r[0] = 1 - 2 * (c * c + d * d); r[1] = 2 * (b * c - a * d); r[2] = 2 * (b * d + a * c);
        r[3] = 2 * (b * c + a * d); r[4] = 1 - 2 * (b * b + d * d); r[5] = 2 * (c * d - a * b);
        r[6] = 2 * (b * d - a * c); r[7] = 2 * (c * d + a * b); r[8] = 1 - 2 * (b * b + c * c);
        foreach (m[e]) begin
            m[e] = int'(r[e] * 1073741823.0) + $urandom_range(0, 6) - 3;
        end
    endtask

    task automatic send_matrix(input int m[9]);
        in_ch.m00 <= m[0]; in_ch.m01 <= m[1]; in_ch.m02 <= m[2];
        in_ch.m10 <= m[3]; in_ch.m11 <= m[4]; in_ch.m12 <= m[5];
        in_ch.m20 <= m[6]; in_ch.m21 <= m[7]; in_ch.m22 <= m[8];
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic idle_gap();
        int n;
        if (($urandom % 3) == 0) begin
            n = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    initial begin
        int m[9];
        int dir[$][9];
        int burst;
        int waited;
        in_ch.valid = 1'b0;
        {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
         in_ch.m20, in_ch.m21, in_ch.m22} = '0;
        sent = 0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Identity, half turns about each axis, quarter turns about z and x, all-zero, extremes and non-rotations.
        dir.insert(dir.size(), '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
        dir.insert(dir.size(), '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
        dir.insert(dir.size(), '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE});
        dir.insert(dir.size(), '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE});
        dir.insert(dir.size(), '{0, 0, 0, 0, 0, 0, 0, 0, 0});
        dir.insert(dir.size(), '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
        dir.insert(dir.size(), '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE});
        dir.insert(dir.size(), '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
        dir.insert(dir.size(), '{-ONE, ONE, ONE, ONE, -ONE, ONE, ONE, ONE, -ONE});
        dir.insert(dir.size(), '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                 32'h7FFFFFFF});
        dir.insert(dir.size(), '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                 32'h80000000});
        dir.insert(dir.size(), '{-1, 5, -7, 9, -1, 3, 8, -2, -1});
        dir.insert(dir.size(), '{ONE, 0, 0, 0, 0, ONE, 0, -ONE, 0});
        dir.insert(dir.size(), '{0, 0, 0, 0, 0, 0, 0, 0, 1});
        dir.insert(dir.size(), '{5, 0, 0, 0, 5, 0, 0, 0, 5});
        dir.insert(dir.size(), '{-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE});
        foreach (dir[n]) begin
            send_matrix(dir[n]);
            idle_gap();
        end

        while (sent < dir.size() + N_RANDOM) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                if (($urandom % 4) != 0) begin
                    make_rotation(m);
                end else begin
                    foreach (m[e]) m[e] = pick_entry();
                end
                send_matrix(m);
            end
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 200000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (120) @(negedge i_clk);

        $display("Sent %0d matrices, mostly rotations plus random and extreme entries.", sent);
        $display("Checked %0d quaternions, %0d of them flagged degenerate.",
                 results, degen_count);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
